FILE: rtl/core/ptpd_pkg.sv
package ptpd_pkg;

  localparam int CoordW  = 32;
  localparam int EntW    = 16;
  localparam int ProdW   = CoordW + EntW;
  localparam int SumW    = ProdW + 2;
  localparam int MagW    = 48;
  localparam int QuoW    = 32;
  localparam int CfgW    = 64;
  localparam int CfgIdxW = 2;
  localparam int NumRows = 4;
  localparam int NumCols = 4;
  localparam int QDepth  = 4;
  localparam int QPtrW   = $clog2(QDepth);

  typedef logic [CfgW-1:0] row_t;
  typedef logic signed [SumW-1:0] sum_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ROW0 = 2'd0,
    REG_ROW1 = 2'd1,
    REG_ROW2 = 2'd2,
    REG_ROW3 = 2'd3
  } cfg_reg_t;

  localparam row_t ROW0_RST = 64'h0000_0000_0000_0100;
  localparam row_t ROW1_RST = 64'h0000_0000_0100_0000;
  localparam row_t ROW2_RST = 64'h0000_0100_0000_0000;
  localparam row_t ROW3_RST = 64'h0100_0000_0000_0000;

  typedef struct packed {
    sum_t [NumCols-1:0] acc;
  } sums_t;

  function automatic logic signed [EntW-1:0] mat_entry(row_t r, int col);
    return r[col*EntW +: EntW];
  endfunction

endpackage

FILE: rtl/core/ptpd_in_if.sv
interface ptpd_in_if import ptpd_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [CoordW-1:0] in_x;
  logic signed [CoordW-1:0] in_y;
  logic signed [CoordW-1:0] in_z;

  modport source(output valid, output in_x, output in_y, output in_z, input ready);
  modport sink(input valid, input in_x, input in_y, input in_z, output ready);
endinterface

FILE: rtl/core/ptpd_out_if.sv
interface ptpd_out_if import ptpd_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [CoordW-1:0] out_x;
  logic signed [CoordW-1:0] out_y;
  logic signed [CoordW-1:0] out_z;
  logic w_was_zero;
  logic saturated;

  modport source(output valid, output out_x, output out_y, output out_z,
                 output w_was_zero, output saturated, input ready);
  modport sink(input valid, input out_x, input out_y, input out_z,
               input w_was_zero, input saturated, output ready);
endinterface

FILE: rtl/core/ptpd_front.sv
module ptpd_front import ptpd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  ptpd_in_if.sink    in_ch,
  input  row_t [NumRows-1:0] rows,
  output logic       q_valid,
  output sums_t      q_data,
  input  logic       q_ready
);

  logic signed [ProdW-1:0] prod_r [NumCols][NumRows];
  logic s1_valid_r;
  logic s2_valid_r;
  logic adv1;
  logic adv2;

  assign adv2 = !s2_valid_r || q_ready;
  assign adv1 = !s1_valid_r || adv2;
  assign in_ch.ready = adv1;
  assign q_valid = s2_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (adv1) s1_valid_r <= in_ch.valid;
      if (adv2) s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_ch.valid) begin
      for (int c = 0; c < NumCols; c++) begin
        prod_r[c][0] <= ProdW'(in_ch.in_x) * ProdW'(mat_entry(rows[0], c));
        prod_r[c][1] <= ProdW'(in_ch.in_y) * ProdW'(mat_entry(rows[1], c));
        prod_r[c][2] <= ProdW'(in_ch.in_z) * ProdW'(mat_entry(rows[2], c));
        prod_r[c][3] <= ProdW'(signed'({mat_entry(rows[3], c), 16'h0000}));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && s1_valid_r) begin
      for (int c = 0; c < NumCols; c++) begin
        q_data.acc[c] <= SumW'(prod_r[c][0]) + SumW'(prod_r[c][1])
                       + SumW'(prod_r[c][2]) + SumW'(prod_r[c][3]);
      end
    end
  end

endmodule

FILE: rtl/core/ptpd_fifo.sv
module ptpd_fifo import ptpd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr_valid,
  output logic  wr_ready,
  input  sums_t wr_data,
  output logic  rd_valid,
  input  logic  rd_ready,
  output sums_t rd_data
);

  sums_t mem [QDepth];
  logic [QPtrW-1:0] wr_ptr_r;
  logic [QPtrW-1:0] rd_ptr_r;
  logic [QPtrW:0]   count_r;
  logic push;
  logic pop;

  assign wr_ready = count_r != (QPtrW+1)'(QDepth);
  assign rd_valid = count_r != '0;
  assign push = wr_valid && wr_ready;
  assign pop  = rd_valid && rd_ready;
  assign rd_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= wr_data;
  end

endmodule

FILE: rtl/core/ptpd_back.sv
module ptpd_back import ptpd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  q_valid,
  output logic  q_ready,
  input  sums_t q_data,
  ptpd_out_if.source out_ch
);

  typedef struct packed {
    logic [MagW-1:0] rem;
    logic [QuoW-1:0] dbits;
    logic [QuoW-1:0] quo;
    logic            neg;
    logic            ovf;
  } divc_t;

  typedef struct packed {
    logic [MagW-1:0] w;
    logic            wz;
    divc_t [2:0]     c;
  } stage_t;

  stage_t st_r [QuoW+1];
  logic [QuoW:0] v_r;
  stage_t st0;
  logic adv;
  logic out_valid_r;
  logic signed [CoordW-1:0] res_nxt [3];
  logic sat_nxt;
  logic signed [CoordW-1:0] res_r [3];
  logic wz_r;
  logic sat_r;

  function automatic divc_t div_step(divc_t d, logic [MagW-1:0] w, logic wz);
    logic [MagW:0] t;
    logic [MagW:0] diff;
    divc_t res;
    t = {d.rem, d.dbits[QuoW-1]};
    diff = t - {1'b0, w};
    res = d;
    if (!wz) begin
      res.dbits = {d.dbits[QuoW-2:0], 1'b0};
      if (!diff[MagW]) begin
        res.rem = diff[MagW-1:0];
        res.quo = {d.quo[QuoW-2:0], 1'b1};
      end else begin
        res.rem = t[MagW-1:0];
        res.quo = {d.quo[QuoW-2:0], 1'b0};
      end
    end
    return res;
  endfunction

  function automatic logic [MagW-1:0] mag_of(sum_t v);
    sum_t a;
    a = v[SumW-1] ? -v : v;
    return a[MagW-1:0];
  endfunction

  assign adv = !out_valid_r || out_ch.ready;
  assign q_ready = adv;

  always_comb begin
    logic [MagW-1:0] m;
    logic sgn;
    logic wneg;
    st0.w  = mag_of(q_data.acc[3]);
    st0.wz = q_data.acc[3] == '0;
    wneg   = q_data.acc[3][SumW-1];
    for (int c = 0; c < 3; c++) begin
      m   = mag_of(q_data.acc[c]);
      sgn = q_data.acc[c][SumW-1];
      if (st0.wz) begin
        st0.c[c].rem   = '0;
        st0.c[c].dbits = '0;
        st0.c[c].quo   = m[QuoW+7:8];
        st0.c[c].ovf   = |m[MagW-1:QuoW+8];
        st0.c[c].neg   = sgn;
      end else begin
        st0.c[c].rem   = MagW'(m[MagW-1:16]);
        st0.c[c].dbits = {m[15:0], 16'h0000};
        st0.c[c].quo   = '0;
        st0.c[c].ovf   = {16'h0000, m} >= {st0.w, 16'h0000};
        st0.c[c].neg   = sgn ^ wneg;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[QuoW-1:0], q_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0] <= st0;
      for (int k = 0; k < QuoW; k++) begin
        st_r[k+1].w  <= st_r[k].w;
        st_r[k+1].wz <= st_r[k].wz;
        for (int c = 0; c < 3; c++) begin
          st_r[k+1].c[c] <= div_step(st_r[k].c[c], st_r[k].w, st_r[k].wz);
        end
      end
    end
  end

  always_comb begin
    divc_t d;
    logic n;
    sat_nxt = 1'b0;
    for (int c = 0; c < 3; c++) begin
      d = st_r[QuoW].c[c];
      n = d.neg && (d.quo != '0);
      if (d.ovf) begin
        sat_nxt = 1'b1;
        res_nxt[c] = d.neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else if (n) begin
        if (d.quo > 32'h8000_0000) begin
          sat_nxt = 1'b1;
          res_nxt[c] = 32'sh8000_0000;
        end else begin
          res_nxt[c] = -$signed(d.quo);
        end
      end else if (d.quo[QuoW-1]) begin
        sat_nxt = 1'b1;
        res_nxt[c] = 32'sh7FFF_FFFF;
      end else begin
        res_nxt[c] = $signed(d.quo);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v_r[QuoW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v_r[QuoW]) begin
      res_r <= res_nxt;
      wz_r  <= st_r[QuoW].wz;
      sat_r <= sat_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_x      = res_r[0];
  assign out_ch.out_y      = res_r[1];
  assign out_ch.out_z      = res_r[2];
  assign out_ch.w_was_zero = wz_r;
  assign out_ch.saturated  = sat_r;

endmodule

FILE: rtl/core/point_transform_perspective_divide.sv
// Pipeline: 2 multiply/sum stages, the queue, 1 divider entry stage, 32 radix-2 divider
// stages and an output register.
// Throughput: one point per cycle; the three pipelined restoring dividers take a new
// quotient every cycle and stall together only when the result is not taken.
// Reset: synchronous active-low rst_n empties the pipeline and queue and loads the
// identity matrix into the four row registers.
module point_transform_perspective_divide import ptpd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  ptpd_in_if.sink            in_ch,
  ptpd_out_if.source         out_ch,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data
);

  row_t [NumRows-1:0] rows_r;
  logic  f_valid;
  logic  f_ready;
  sums_t f_data;
  logic  b_valid;
  logic  b_ready;
  sums_t b_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r[0] <= ROW0_RST;
      rows_r[1] <= ROW1_RST;
      rows_r[2] <= ROW2_RST;
      rows_r[3] <= ROW3_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ROW0: rows_r[0] <= cfg_data;
        REG_ROW1: rows_r[1] <= cfg_data;
        REG_ROW2: rows_r[2] <= cfg_data;
        REG_ROW3: rows_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  ptpd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .rows    (rows_r),
    .q_valid (f_valid),
    .q_data  (f_data),
    .q_ready (f_ready)
  );

  ptpd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_data),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_data  (b_data)
  );

  ptpd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (b_valid),
    .q_ready (b_ready),
    .q_data  (b_data),
    .out_ch  (out_ch)
  );

endmodule
